FILE: rtl/bcs_pkg.sv
// Shared types and constants for the barometer compensation and smoothing block.
// Used by bcs_ctrl, bcs_datapath, the top level and the checker; no dependencies.
package bcs_pkg;

  localparam int CAL_W      = 16;
  localparam int RAW_W      = 24;
  localparam int TEMP_OUT_W = 15;
  localparam int PRES_W     = 17;
  localparam int IDX_W      = 3;

  localparam int DT_W    = 25;
  localparam int TEMPI_W = 19;
  localparam int OFF_W   = 40;
  localparam int SENS_W  = 40;
  localparam int SQ_W    = 35;
  localparam int SQX_W   = 38;
  localparam int PACC_W  = 64;
  localparam int PCALC_W = 48;
  localparam int MUL_W   = 26;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int GAIN_W  = 17;
  localparam int SENS_LO_W = 20;

  localparam int TEMP_REF  = 2000;
  localparam int TEMP_VLOW = -1500;
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRES_MIN  = 1000;
  localparam int PRES_MAX  = 120000;

  localparam logic [CAL_W-1:0] GAIN_RESET = 16'd31789;

  typedef enum logic [IDX_W-1:0] {
    CFG_CAL_SENS,
    CFG_CAL_OFFSET,
    CFG_CAL_SENS_TEMPCO,
    CFG_CAL_OFFSET_TEMPCO,
    CFG_CAL_REF_TEMP,
    CFG_CAL_TEMP_COEF,
    CFG_FILTER_GAIN
  } cfg_idx_t;

  typedef struct packed {
    logic [CAL_W-1:0] cal_sens;
    logic [CAL_W-1:0] cal_offset;
    logic [CAL_W-1:0] cal_sens_tempco;
    logic [CAL_W-1:0] cal_offset_tempco;
    logic [CAL_W-1:0] cal_ref_temp;
    logic [CAL_W-1:0] cal_temp_coef;
    logic [CAL_W-1:0] filter_gain;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEMP_MUL,
    ST_OFF_MUL,
    ST_SENS_MUL,
    ST_SQ1_MUL,
    ST_SQ2_MUL,
    ST_CORR2,
    ST_PLO_MUL,
    ST_PHI_MUL,
    ST_PSUM,
    ST_PCALC,
    ST_FILT,
    ST_FLO_MUL,
    ST_FHI_MUL,
    ST_FSUM,
    ST_DONE
  } step_t;

  typedef struct packed {
    step_t step;
    logic  load_in;
    logic  load_out;
    logic  first;
  } cmd_t;

endpackage

FILE: rtl/bcs_ctrl.sv
// Sequencer for the compensation datapath: steps one beat through the shared
// multiplier schedule and owns the output valid flag. Depends on bcs_pkg.
module bcs_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output bcs_pkg::cmd_t cmd
);
  import bcs_pkg::*;

  step_t state_r, state_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  first_r, first_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    first_nxt     = first_r;
    cmd.step      = state_r;
    cmd.load_in   = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.first     = first_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_TEMP_MUL;
        end
      end
      ST_TEMP_MUL, ST_OFF_MUL, ST_SENS_MUL, ST_SQ1_MUL, ST_SQ2_MUL, ST_CORR2,
      ST_PLO_MUL, ST_PHI_MUL, ST_PSUM, ST_PCALC, ST_FILT, ST_FLO_MUL,
      ST_FHI_MUL: begin
        state_nxt = step_t'(state_r + 4'd1);
      end
      ST_FSUM: begin
        first_nxt = 1'b0;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/bcs_datapath.sv
// Compensation and filter datapath around one shared registered 26x26 multiplier.
// Driven step by step by bcs_ctrl commands. Depends on bcs_pkg.
module bcs_datapath #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  bcs_pkg::cfg_t                       cfg,
  input  bcs_pkg::cmd_t                       cmd,
  input  logic [bcs_pkg::RAW_W-1:0]           raw_pressure,
  input  logic [bcs_pkg::RAW_W-1:0]           raw_temperature,
  output logic signed [bcs_pkg::TEMP_OUT_W-1:0] temp_centideg,
  output logic [bcs_pkg::PRES_W-1:0]          pressure_centimbar,
  output logic [bcs_pkg::PRES_W-1:0]          pressure_smoothed
);
  import bcs_pkg::*;

  localparam int F     = GAIN_FRAC_BITS;
  localparam int ACC_W = F + PRES_W + 1;
  localparam logic [31:0] UNITY = 32'd1 << F;

  logic        [RAW_W-1:0]      d1_r;
  logic signed [DT_W-1:0]       dt_r;
  logic signed [TEMPI_W-1:0]    temp_r;
  logic signed [OFF_W-1:0]      off_r;
  logic signed [SENS_W-1:0]     sens_r;
  logic signed [PACC_W-1:0]     pacc_r;
  logic        [PRES_W-1:0]     p_r;
  logic signed [TEMP_OUT_W-1:0] temp_c_r;
  logic signed [ACC_W-1:0]      diff_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic        [PRES_W-1:0]     part_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [TEMP_OUT_W-1:0] temp_out_r;
  logic        [PRES_W-1:0]     pres_out_r;
  logic        [PRES_W-1:0]     smooth_out_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [TEMPI_W-1:0] tmd, tpl;
  logic        [GAIN_W-1:0]  gain;
  logic        [SQ_W-1:0]    sq;
  logic        [SQX_W-1:0]   sq5, sq7, sq11;
  logic signed [PCALC_W-1:0] pdiff, ppre;
  logic signed [ACC_W-1:0]   target;

  always_comb begin
    tmd    = temp_r - TEMPI_W'(TEMP_REF);
    tpl    = temp_r - TEMPI_W'(TEMP_VLOW);
    gain   = (32'(cfg.filter_gain) > UNITY) ? UNITY[GAIN_W-1:0] : GAIN_W'(cfg.filter_gain);
    sq     = prod_r[SQ_W-1:0];
    sq5    = (SQX_W'(sq) << 2) + SQX_W'(sq);
    sq7    = (SQX_W'(sq) << 3) - SQX_W'(sq);
    sq11   = (SQX_W'(sq) << 3) + (SQX_W'(sq) << 1) + SQX_W'(sq);
    pdiff  = PCALC_W'(pacc_r >>> 21) - PCALC_W'(off_r);
    ppre   = pdiff >>> 15;
    target = $signed({1'b0, p_r, {F{1'b0}}});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      ST_TEMP_MUL: begin
        mul_a = MUL_W'(dt_r);
        mul_b = MUL_W'($signed({1'b0, cfg.cal_temp_coef}));
      end
      ST_OFF_MUL: begin
        mul_a = MUL_W'($signed({1'b0, cfg.cal_offset_tempco}));
        mul_b = MUL_W'(dt_r);
      end
      ST_SENS_MUL: begin
        mul_a = MUL_W'($signed({1'b0, cfg.cal_sens_tempco}));
        mul_b = MUL_W'(dt_r);
      end
      ST_SQ1_MUL: begin
        mul_a = MUL_W'(tmd);
        mul_b = MUL_W'(tmd);
      end
      ST_SQ2_MUL: begin
        mul_a = MUL_W'(tpl);
        mul_b = MUL_W'(tpl);
      end
      ST_PLO_MUL: begin
        mul_a = MUL_W'($signed({1'b0, d1_r}));
        mul_b = MUL_W'($signed({1'b0, sens_r[SENS_LO_W-1:0]}));
      end
      ST_PHI_MUL: begin
        mul_a = MUL_W'($signed({1'b0, d1_r}));
        mul_b = MUL_W'($signed(sens_r[SENS_W-1:SENS_LO_W]));
      end
      ST_FLO_MUL: begin
        mul_a = MUL_W'($signed({1'b0, diff_r[F-1:0]}));
        mul_b = MUL_W'($signed({1'b0, gain}));
      end
      ST_FHI_MUL: begin
        mul_a = MUL_W'($signed(diff_r[ACC_W-1:F]));
        mul_b = MUL_W'($signed({1'b0, gain}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      d1_r <= raw_pressure;
      dt_r <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.cal_ref_temp, 8'h00});
    end
    case (cmd.step)
      ST_OFF_MUL: temp_r <= TEMPI_W'(prod_r >>> 23) + TEMPI_W'(TEMP_REF);
      ST_SENS_MUL: begin
        off_r <= OFF_W'($signed({1'b0, cfg.cal_offset, 16'h0000})) + OFF_W'(prod_r >>> 7);
      end
      ST_SQ1_MUL: begin
        sens_r <= SENS_W'($signed({1'b0, cfg.cal_sens, 15'h0000})) + SENS_W'(prod_r >>> 8);
      end
      ST_SQ2_MUL: begin
        if (temp_r < TEMP_REF) begin
          off_r  <= off_r - OFF_W'(sq5 >> 1);
          sens_r <= sens_r - SENS_W'(sq5 >> 2);
        end
      end
      ST_CORR2: begin
        if (temp_r < TEMP_VLOW) begin
          off_r  <= off_r - OFF_W'(sq7);
          sens_r <= sens_r - SENS_W'(sq11 >> 1);
        end
      end
      ST_PHI_MUL: pacc_r <= PACC_W'(prod_r);
      ST_PSUM:    pacc_r <= pacc_r + (PACC_W'(prod_r) << SENS_LO_W);
      ST_PCALC: begin
        if (ppre < PRES_MIN) begin
          p_r <= PRES_W'(PRES_MIN);
        end else if (ppre > PRES_MAX) begin
          p_r <= PRES_W'(PRES_MAX);
        end else begin
          p_r <= ppre[PRES_W-1:0];
        end
        if (temp_r < TEMP_MIN) begin
          temp_c_r <= TEMP_OUT_W'(TEMP_MIN);
        end else if (temp_r > TEMP_MAX) begin
          temp_c_r <= TEMP_OUT_W'(TEMP_MAX);
        end else begin
          temp_c_r <= temp_r[TEMP_OUT_W-1:0];
        end
      end
      ST_FILT:    diff_r <= target - acc_r;
      ST_FHI_MUL: part_r <= prod_r[F+PRES_W-1:F];
      ST_FSUM: begin
        if (cmd.first) begin
          acc_r <= target;
        end else begin
          acc_r <= acc_r + ACC_W'(prod_r) + ACC_W'(part_r);
        end
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      temp_out_r   <= temp_c_r;
      pres_out_r   <= p_r;
      smooth_out_r <= acc_r[F+PRES_W-1:F];
    end
  end

  assign temp_centideg      = temp_out_r;
  assign pressure_centimbar = pres_out_r;
  assign pressure_smoothed  = smooth_out_r;

endmodule

FILE: rtl/baro_compensate_and_smooth.sv
// Top level of the barometer compensation and smoothing block: calibration
// registers, sequencer and datapath. Depends on bcs_pkg, bcs_ctrl, bcs_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat of raw pressure and raw
//   temperature conversions. Output channel (out_valid/out_ready) returns one
//   beat per input: clamped temperature (0.01 deg), clamped pressure and the
//   low-pass filtered pressure (0.01 mbar).
//   Configuration: cfg_we writes cfg_wdata to register cfg_index at the clock
//   edge; indexes above the filter gain are dropped. Write only while idle.
//   Result timing: out_valid is registered and rises once the beat has stepped
//   through ST_TEMP_MUL to ST_FSUM and ST_DONE finds the output free.
//   Input rate: a new input beat is taken only in ST_IDLE, after the last beat
//   has left ST_DONE; the schedule of nine products through one shared 26x26 registered multiplier sets this bound.
//   A finished result sits in the output register, so the next input beat is
//   taken while the receiver stalls; a second result then waits in the last
//   step until the output register is drained.
//   Reset (rst_n low, synchronous): calibration words clear, the gain returns
//   to its default, both channels go empty and the next sample loads the
//   filter directly.
module baro_compensate_and_smooth #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bcs_pkg::RAW_W-1:0]              in_raw_pressure,
  input  logic [bcs_pkg::RAW_W-1:0]              in_raw_temperature,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bcs_pkg::TEMP_OUT_W-1:0]  out_temp_centideg,
  output logic [bcs_pkg::PRES_W-1:0]             out_pressure_centimbar,
  output logic [bcs_pkg::PRES_W-1:0]             out_pressure_smoothed,
  input  logic                                   cfg_we,
  input  logic [bcs_pkg::IDX_W-1:0]              cfg_index,
  input  logic [bcs_pkg::CAL_W-1:0]              cfg_wdata
);
  import bcs_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal_sens          <= '0;
      cfg_r.cal_offset        <= '0;
      cfg_r.cal_sens_tempco   <= '0;
      cfg_r.cal_offset_tempco <= '0;
      cfg_r.cal_ref_temp      <= '0;
      cfg_r.cal_temp_coef     <= '0;
      cfg_r.filter_gain       <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CAL_SENS:          cfg_r.cal_sens          <= cfg_wdata;
        CFG_CAL_OFFSET:        cfg_r.cal_offset        <= cfg_wdata;
        CFG_CAL_SENS_TEMPCO:   cfg_r.cal_sens_tempco   <= cfg_wdata;
        CFG_CAL_OFFSET_TEMPCO: cfg_r.cal_offset_tempco <= cfg_wdata;
        CFG_CAL_REF_TEMP:      cfg_r.cal_ref_temp      <= cfg_wdata;
        CFG_CAL_TEMP_COEF:     cfg_r.cal_temp_coef     <= cfg_wdata;
        CFG_FILTER_GAIN:       cfg_r.filter_gain       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  bcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bcs_datapath #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .cfg                (cfg_r),
    .cmd                (cmd),
    .raw_pressure       (in_raw_pressure),
    .raw_temperature    (in_raw_temperature),
    .temp_centideg      (out_temp_centideg),
    .pressure_centimbar (out_pressure_centimbar),
    .pressure_smoothed  (out_pressure_smoothed)
  );

endmodule

FILE: rtl/bcs_checker.sv
// Port-level checks for baro_compensate_and_smooth, attached by bind.
// Depends on bcs_pkg and the top level's port list.
module bcs_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [bcs_pkg::TEMP_OUT_W-1:0] out_temp_centideg,
  input logic [bcs_pkg::PRES_W-1:0]            out_pressure_centimbar,
  input logic [bcs_pkg::PRES_W-1:0]            out_pressure_smoothed
);
  import bcs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure_smoothed))
    else $error("output beat dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is in work");

  a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pressure_centimbar >= PRES_MIN && out_pressure_centimbar <= PRES_MAX &&
                  out_pressure_smoothed >= PRES_MIN && out_pressure_smoothed <= PRES_MAX)
    else $error("pressure out of range");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp_centideg >= TEMP_MIN && out_temp_centideg <= TEMP_MAX)
    else $error("temperature out of range");

endmodule

bind baro_compensate_and_smooth bcs_checker u_bcs_checker (.*);

FILE: verif/bcs_compensation_monitor.sv
`timescale 1ns / 100ps
// Watches the channels of baro_compensate_and_smooth, predicts each compensated reading
// and compares it with the result beats. Depends on bcs_pkg.
module bcs_compensation_monitor
  import bcs_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [RAW_W-1:0]             in_raw_pressure,
  input  logic [RAW_W-1:0]             in_raw_temperature,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [TEMP_OUT_W-1:0] out_temp_centideg,
  input  logic [PRES_W-1:0]            out_pressure_centimbar,
  input  logic [PRES_W-1:0]            out_pressure_smoothed,
  input  logic                         cfg_we,
  input  logic [IDX_W-1:0]             cfg_index,
  input  logic [CAL_W-1:0]             cfg_wdata,
  output int                           fail_count,
  output int                           outstanding,
  output int                           results_seen
);

  typedef struct packed {
    logic [TEMP_OUT_W-1:0] temp;
    logic [PRES_W-1:0]     pres;
    logic [PRES_W-1:0]     smooth;
  } reading_t;

  cfg_t     cal;
  longint   smooth_acc;
  bit       smooth_loaded;
  reading_t readings_due [$];
  int       errs;
  int       seen;

  function automatic reading_t compensate_reading(input longint d1, input longint d2);
    longint k_sens, k_off, k_sens_tc, k_off_tc, k_tref, k_tcoef, gain, unity;
    longint dt, temp, off, sens, off2, sens2, sq, pres, target, sm;
    reading_t r;
    k_sens    = cal.cal_sens;
    k_off     = cal.cal_offset;
    k_sens_tc = cal.cal_sens_tempco;
    k_off_tc  = cal.cal_offset_tempco;
    k_tref    = cal.cal_ref_temp;
    k_tcoef   = cal.cal_temp_coef;
    gain      = cal.filter_gain;

    dt   = d2 - k_tref * 256;
    temp = TEMP_REF + ((dt * k_tcoef) >>> 23);
    off  = k_off * 65536 + ((k_off_tc * dt) >>> 7);
    sens = k_sens * 32768 + ((k_sens_tc * dt) >>> 8);

    if (temp < TEMP_REF) begin
      sq    = (temp - TEMP_REF) * (temp - TEMP_REF);
      off2  = 5 * sq / 2;
      sens2 = 5 * sq / 4;
      if (temp < TEMP_VLOW) begin
        sq    = (temp - TEMP_VLOW) * (temp - TEMP_VLOW);
        off2  = off2 + 7 * sq;
        sens2 = sens2 + 11 * sq / 2;
      end
      off  = off - off2;
      sens = sens - sens2;
    end

    pres = (((d1 * sens) >>> 21) - off) >>> 15;
    if (pres < PRES_MIN) pres = PRES_MIN;
    if (pres > PRES_MAX) pres = PRES_MAX;
    if (temp < TEMP_MIN) temp = TEMP_MIN;
    if (temp > TEMP_MAX) temp = TEMP_MAX;

    unity  = 64'sd1 <<< GAIN_FRAC_BITS;
    target = pres * unity;
    if (!smooth_loaded) begin
      smooth_acc    = target;
      smooth_loaded = 1'b1;
    end else begin
      if (gain > unity) gain = unity;
      smooth_acc = smooth_acc + (((target - smooth_acc) * gain) >>> GAIN_FRAC_BITS);
    end
    sm = smooth_acc >>> GAIN_FRAC_BITS;

    r.temp   = temp[TEMP_OUT_W-1:0];
    r.pres   = pres[PRES_W-1:0];
    r.smooth = sm[PRES_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      cal             = '0;
      cal.filter_gain = GAIN_RESET;
      smooth_acc      = 0;
      smooth_loaded   = 1'b0;
      readings_due.delete();
      errs            = 0;
      seen            = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAL_SENS:          cal.cal_sens          = cfg_wdata;
          CFG_CAL_OFFSET:        cal.cal_offset        = cfg_wdata;
          CFG_CAL_SENS_TEMPCO:   cal.cal_sens_tempco   = cfg_wdata;
          CFG_CAL_OFFSET_TEMPCO: cal.cal_offset_tempco = cfg_wdata;
          CFG_CAL_REF_TEMP:      cal.cal_ref_temp      = cfg_wdata;
          CFG_CAL_TEMP_COEF:     cal.cal_temp_coef     = cfg_wdata;
          CFG_FILTER_GAIN:       cal.filter_gain       = cfg_wdata;
          default: ;
        endcase
      end
      // pop before push: a beat taken this edge cannot already be on the output
      if (out_valid && out_ready) begin
        seen++;
        if (readings_due.size() == 0) begin
          $error("result beat with no reading due: temp %0d pres %0d smooth %0d",
                 out_temp_centideg, out_pressure_centimbar, out_pressure_smoothed);
          errs++;
        end else begin
          want = readings_due.pop_front();
          if (out_temp_centideg !== want.temp) begin
            $error("temp_centideg: expected %0d, actual %0d",
                   $signed(want.temp), out_temp_centideg);
            errs++;
          end
          if (out_pressure_centimbar !== want.pres) begin
            $error("pressure_centimbar: expected %0d, actual %0d",
                   want.pres, out_pressure_centimbar);
            errs++;
          end
          if (out_pressure_smoothed !== want.smooth) begin
            $error("pressure_smoothed: expected %0d, actual %0d",
                   want.smooth, out_pressure_smoothed);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        readings_due.push_back(compensate_reading(in_raw_pressure, in_raw_temperature));
    end
    fail_count   <= errs;
    outstanding  <= readings_due.size();
    results_seen <= seen;
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Stimulus and verdict for baro_compensate_and_smooth; prediction and comparison live in
// bcs_compensation_monitor. Depends on bcs_pkg and the block's RTL.
module testbench;
  import bcs_pkg::*;

  localparam int GAIN_FRAC   = 16;
  localparam int LATENCY     = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 75;
  localparam logic [RAW_W-1:0] NOM_D1 = 24'd9085466;
  localparam longint RAW_MAX = (64'sd1 <<< RAW_W) - 1;
  localparam logic [IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam cfg_t CAL_NOMINAL = '{16'd40127, 16'd36924, 16'd23317, 16'd23282,
                                   16'd33464, 16'd28312, GAIN_RESET};

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RAW_W-1:0] in_raw_pressure = '0;
  logic [RAW_W-1:0] in_raw_temperature = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [TEMP_OUT_W-1:0] out_temp_centideg;
  logic [PRES_W-1:0] out_pressure_centimbar;
  logic [PRES_W-1:0] out_pressure_smoothed;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0] cfg_wdata = '0;

  int   fail_count, outstanding, results_seen;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   beats_sent = 0;
  int   settings_used = 0;
  int   quiet_cycles = 0;
  cfg_t cal_now = '0;

  baro_compensate_and_smooth #(.GAIN_FRAC_BITS(GAIN_FRAC)) dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_raw_pressure, .in_raw_temperature,
    .out_valid, .out_ready, .out_temp_centideg, .out_pressure_centimbar,
    .out_pressure_smoothed,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  bcs_compensation_monitor #(.GAIN_FRAC_BITS(GAIN_FRAC)) comp_mon (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_raw_pressure, .in_raw_temperature,
    .out_valid, .out_ready, .out_temp_centideg, .out_pressure_centimbar,
    .out_pressure_smoothed,
    .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count, .outstanding, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d readings due",
                 QUIET_LIMIT, outstanding);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_raw_pressure    <= d1;
    in_raw_temperature <= d2;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_cal(input cfg_t c);
    cfg_write(CFG_CAL_SENS,          c.cal_sens);
    cfg_write(CFG_CAL_OFFSET,        c.cal_offset);
    cfg_write(CFG_CAL_SENS_TEMPCO,   c.cal_sens_tempco);
    cfg_write(CFG_CAL_OFFSET_TEMPCO, c.cal_offset_tempco);
    cfg_write(CFG_CAL_REF_TEMP,      c.cal_ref_temp);
    cfg_write(CFG_CAL_TEMP_COEF,     c.cal_temp_coef);
    cfg_write(CFG_FILTER_GAIN,       c.filter_gain);
    cfg_write(CFG_UNMAPPED,          CAL_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    cal_now = c;
    settings_used++;
  endtask

  // raw temperature word that lands TEMP exactly on the given value
  function automatic logic [RAW_W-1:0] raw_temp_for(input int target);
    longint num, dt, d2, tref, tcoef;
    tref  = cal_now.cal_ref_temp;
    tcoef = cal_now.cal_temp_coef;
    num   = target - TEMP_REF;
    num   = num * 8388608;
    if (num >= 0) dt = (num + tcoef - 1) / tcoef;
    else dt = num / tcoef;
    d2 = tref * 256 + dt;
    if (d2 < 0) d2 = 0;
    if (d2 > RAW_MAX) d2 = RAW_MAX;
    return d2[RAW_W-1:0];
  endfunction

  initial begin
    cfg_t   c;
    longint d2, tref, mag;
    logic [RAW_W-1:0] d1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: first beat loads the filter, extremes of both raw words
    send_beat('0, '0);
    send_beat('1, '1);
    send_beat('1, '0);
    drain();

    load_cal(CAL_NOMINAL);
    send_beat(NOM_D1, raw_temp_for(TEMP_MAX + 1));
    send_beat(NOM_D1, raw_temp_for(TEMP_MAX));
    send_beat(NOM_D1, raw_temp_for(TEMP_REF));
    send_beat(NOM_D1, raw_temp_for(TEMP_REF - 1));
    send_beat(NOM_D1, raw_temp_for(TEMP_VLOW));
    send_beat(NOM_D1, raw_temp_for(TEMP_VLOW - 1));
    send_beat(NOM_D1, raw_temp_for(TEMP_MIN));
    send_beat(NOM_D1, raw_temp_for(TEMP_MIN - 1));
    send_beat(NOM_D1, '0);
    send_beat(NOM_D1, '1);
    send_beat('0, raw_temp_for(TEMP_REF));
    send_beat('1, raw_temp_for(TEMP_REF));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      c = CAL_NOMINAL;
      case (ph)
        1: c = '1;
        2: c.filter_gain = '0;
        3: c = {$urandom, $urandom, $urandom, CAL_W'($urandom)};
        4: c.filter_gain = 16'd1;
        5: begin
          c.cal_sens          = CAL_W'(c.cal_sens + $urandom_range(4095) - 2048);
          c.cal_offset        = CAL_W'(c.cal_offset + $urandom_range(4095) - 2048);
          c.cal_sens_tempco   = CAL_W'(c.cal_sens_tempco + $urandom_range(4095) - 2048);
          c.cal_offset_tempco = CAL_W'(c.cal_offset_tempco + $urandom_range(4095) - 2048);
          c.cal_ref_temp      = CAL_W'(c.cal_ref_temp + $urandom_range(4095) - 2048);
          c.cal_temp_coef     = CAL_W'(c.cal_temp_coef + $urandom_range(4095) - 2048);
          c.filter_gain       = CAL_W'($urandom);
        end
        default: ;
      endcase
      load_cal(c);

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase

      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i == PHASE_BEATS / 2) drain();
        if ($urandom_range(99) < 70) begin
          // plausible conversion pair near the reference temperature
          tref = cal_now.cal_ref_temp;
          if ($urandom_range(3) == 0) mag = $urandom_range(3000000);
          else mag = $urandom_range(200000);
          d2 = $urandom_range(1) ? tref * 256 + mag : tref * 256 - mag;
          if (d2 < 0) d2 = 0;
          if (d2 > RAW_MAX) d2 = RAW_MAX;
          d1 = RAW_W'($urandom_range(10000000, 4000000));
          send_beat(d1, d2[RAW_W-1:0]);
        end else begin
          send_beat(RAW_W'($urandom), RAW_W'($urandom));
        end
      end
      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    $display("Sent %0d beats and checked %0d readings over %0d calibration settings,",
             beats_sent, results_seen, settings_used);
    $display("covering saturation, both cold corrections and idle/stall mixes up to 75%%.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bcs_pkg.sv
rtl/bcs_ctrl.sv
rtl/bcs_datapath.sv
rtl/baro_compensate_and_smooth.sv
rtl/bcs_checker.sv
verif/bcs_compensation_monitor.sv
verif/testbench.sv
